// ===== design/nac_pkg.sv =====
package nac_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int LAG_W        = 18;
	localparam int CORR_W       = 32;
	localparam int NUM_LAGS_W   = 7;
	localparam int LAG_STEP_W   = 12;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 12;

	localparam int DEF_MAX_SAMPLES = 4096;
	localparam int DEF_MAX_LAGS    = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_LAGS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_STEP = 1'd1;

	localparam logic [NUM_LAGS_W-1:0] RST_NUM_LAGS = 7'd64;
	localparam logic [LAG_STEP_W-1:0] RST_LAG_STEP = 12'd1;

	// saturation limits of the q4.28 result
	localparam logic [CORR_W-1:0] CORR_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [CORR_W-1:0] CORR_NEG_MAX = 32'h8000_0000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} nac_in_t;

	typedef struct packed {
		logic [LAG_W-1:0]         lag_samples;
		logic signed [CORR_W-1:0] correlation;
		logic                     invalid;
		logic                     final_result;
	} nac_out_t;

endpackage

// ===== design/normalized_autocorrelation.sv =====
// normalized autocorrelation of a sample series
//
// in_data carries one signed q16.16 sample per transaction on a valid/ready
// channel; the transaction with last set closes the series. samples past
// MAX_SAMPLES are dropped, their last mark still closes the series.
// loading takes one sample per cycle into the sample memory.
// after last, the block forms the mean with an iterative divider of width NW,
// then runs a variance pass over the memory (two read ports), then for every
// lag n*lag_step a lag pass, a bit-serial scaling multiply and a divide,
// where NW = 2*32 + 2*clog2(MAX_SAMPLES+1) + 32. invalid lags skip all that.
// each lag result sits in the output register until out_ready takes it;
// a stalled receiver simply holds the sequencer, nothing is lost.
// in_ready is low from the last sample until the final result is taken.
// cfg_we writes num_lags (index 0) or lag_step (index 1).
// reset clears the sample count, the running sum and all control state,
// and restores num_lags to 64 and lag_step to 1; the memory is not cleared.
module normalized_autocorrelation import nac_pkg::*; #(
	parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
	parameter int MAX_LAGS    = DEF_MAX_LAGS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  nac_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output nac_out_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int SW   = SAMPLE_W + CW;
	localparam int PW   = 2 * SAMPLE_W + 2;
	localparam int ACW  = PW + CW;
	localparam int MAW  = ACW + CW;
	localparam int NW   = MAW + 30;
	localparam int MCW  = $clog2(CW + 1);
	localparam int CMPW = (LAG_W > CW) ? LAG_W : CW;

	typedef enum logic [3:0] {
		ST_LOAD, ST_MEAN_GO, ST_MEAN_WAIT, ST_PASS, ST_MULT,
		ST_DIV_GO, ST_DIV_WAIT, ST_CHECK, ST_EMIT
	} state_t;

	state_t state_q;

	logic [NUM_LAGS_W-1:0] num_lags_q;
	logic [LAG_STEP_W-1:0] lag_step_q;
	logic [NUM_LAGS_W-1:0] nl;

	logic [CW-1:0]        cnt_q;
	logic signed [SW-1:0] sum_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic                 mneg_q;

	logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

	// pass engine
	logic [CW-1:0] p_i_q, p_span_q, p_t_q;
	logic          var_pass_q;
	logic          issue;
	logic          v1_q, v2_q, v3_q;
	logic [SAMPLE_W-1:0] rd_a_s1, rd_b_s1;
	logic signed [SAMPLE_W:0] da_s2, db_s2;
	logic signed [PW-1:0] prod_s3;
	logic signed [ACW-1:0] acc_q;
	logic [ACW-1:0]       var_q;
	logic [ACW-1:0]       acc_mag;

	// scaling multiply
	logic [MAW-1:0] ma_q, mb_q, numacc_q, denacc_q;
	logic [CW-1:0]  cnt_sh_q, span_sh_q;
	logic [MCW-1:0] mc_q;
	logic           cneg_q;

	// lag sequencing
	logic [NUM_LAGS_W-1:0] n_q;
	logic [LAG_W-1:0]      t_q;
	logic [CMPW-1:0]       cnt_ext, t_ext;
	logic                  lag_bad;
	logic                  final_lag;

	// divider
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_den, div_quo, div_rem;

	logic signed [SW+1:0] mean_num;
	logic [NW-1:0]        mean_mag;
	logic [SAMPLE_W-1:0]  mean_c;
	logic                 q_big;
	logic [CORR_W-1:0]    corr_c;

	nac_out_t out_q;
	logic     out_valid_q;

	// effective lag count
	always_comb begin
		if (num_lags_q == '0) nl = NUM_LAGS_W'(1);
		else if (num_lags_q > NUM_LAGS_W'(MAX_LAGS)) nl = NUM_LAGS_W'(MAX_LAGS);
		else nl = num_lags_q;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lags_q <= RST_NUM_LAGS;
			lag_step_q <= RST_LAG_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_LAGS: num_lags_q <= cfg_data[NUM_LAGS_W-1:0];
				REG_LAG_STEP: lag_step_q <= cfg_data[LAG_STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// divider operand select and result shaping
	always_comb begin
		mean_num = 2 * (SW+2)'(sum_q) + $signed({2'b00, cnt_q});
		if (state_q == ST_MEAN_GO) begin
			div_num = NW'(mean_num[SW+1] ? -mean_num : mean_num);
			div_den = NW'({cnt_q, 1'b0});
		end else begin
			div_num = NW'({numacc_q, 29'b0}) + NW'(denacc_q);
			div_den = NW'({denacc_q, 1'b0});
		end
		div_start = (state_q == ST_MEAN_GO) || (state_q == ST_DIV_GO);

		mean_mag = mneg_q ? div_quo + NW'(div_rem != '0) : div_quo;
		mean_c   = mneg_q ? SAMPLE_W'(-mean_mag) : mean_mag[SAMPLE_W-1:0];

		q_big = |div_quo[NW-1:CORR_W-1];
		if (cneg_q) corr_c = q_big ? CORR_NEG_MAX : -div_quo[CORR_W-1:0];
		else        corr_c = q_big ? CORR_POS_MAX : div_quo[CORR_W-1:0];

		acc_mag = acc_q[ACW-1] ? ACW'(-acc_q) : ACW'(acc_q);

		cnt_ext   = CMPW'(cnt_q);
		t_ext     = CMPW'(t_q);
		lag_bad   = (t_ext >= cnt_ext) || (var_q == '0);
		final_lag = (n_q == nl - 1'b1);
		issue     = (state_q == ST_PASS) && (p_i_q != p_span_q);
	end

	nac_div #(.W(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// sample memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && (cnt_q < CW'(MAX_SAMPLES)))
			mem[cnt_q[AW-1:0]] <= in_data.sample;
		if (issue) begin
			rd_a_s1 <= mem[p_i_q[AW-1:0]];
			rd_b_s1 <= mem[AW'(p_i_q + p_t_q)];
		end
	end

	// pass datapath: deviation then product
	always_ff @(posedge clk) begin
		da_s2   <= $signed({rd_a_s1[SAMPLE_W-1], rd_a_s1}) - $signed({mean_q[SAMPLE_W-1], mean_q});
		db_s2   <= $signed({rd_b_s1[SAMPLE_W-1], rd_b_s1}) - $signed({mean_q[SAMPLE_W-1], mean_q});
		prod_s3 <= PW'(da_s2) * PW'(db_s2);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			sum_q       <= '0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
			p_i_q       <= '0;
			n_q         <= '0;
			t_q         <= '0;
			mc_q        <= '0;
		end else begin
			v1_q <= issue;
			v2_q <= v1_q;
			v3_q <= v2_q;
			if (v3_q) acc_q <= acc_q + ACW'(prod_s3);
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q < CW'(MAX_SAMPLES)) begin
							cnt_q <= cnt_q + 1'b1;
							sum_q <= sum_q + SW'(in_data.sample);
						end
						if (in_data.last) state_q <= ST_MEAN_GO;
					end
				end
				ST_MEAN_GO: begin
					mneg_q  <= mean_num[SW+1];
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (div_done) begin
						mean_q     <= mean_c;
						var_pass_q <= 1'b1;
						p_i_q      <= '0;
						p_t_q      <= '0;
						p_span_q   <= cnt_q;
						acc_q      <= '0;
						n_q        <= '0;
						t_q        <= '0;
						state_q    <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (issue) p_i_q <= p_i_q + 1'b1;
					else if (!v1_q && !v2_q && !v3_q) begin
						if (var_pass_q) begin
							var_q   <= ACW'(acc_q);
							state_q <= ST_CHECK;
						end else begin
							cneg_q    <= acc_q[ACW-1];
							ma_q      <= MAW'(acc_mag);
							mb_q      <= MAW'(var_q);
							numacc_q  <= '0;
							denacc_q  <= '0;
							cnt_sh_q  <= cnt_q;
							span_sh_q <= p_span_q;
							mc_q      <= MCW'(CW);
							state_q   <= ST_MULT;
						end
					end
				end
				ST_MULT: begin
					if (cnt_sh_q[0]) numacc_q <= numacc_q + ma_q;
					if (span_sh_q[0]) denacc_q <= denacc_q + mb_q;
					ma_q      <= ma_q << 1;
					mb_q      <= mb_q << 1;
					cnt_sh_q  <= cnt_sh_q >> 1;
					span_sh_q <= span_sh_q >> 1;
					mc_q      <= mc_q - 1'b1;
					if (mc_q == MCW'(1)) state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						out_q       <= '{lag_samples: t_q, correlation: corr_c, invalid: 1'b0,
						                 final_result: final_lag};
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_CHECK: begin
					if (lag_bad) begin
						out_q       <= '{lag_samples: t_q, correlation: '0, invalid: 1'b1,
						                 final_result: final_lag};
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end else begin
						var_pass_q <= 1'b0;
						p_i_q      <= '0;
						p_t_q      <= t_q[CW-1:0];
						p_span_q   <= CW'(cnt_ext - t_ext);
						acc_q      <= '0;
						state_q    <= ST_PASS;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_q.final_result) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							n_q     <= n_q + 1'b1;
							t_q     <= t_q + LAG_W'(lag_step_q);
							state_q <= ST_CHECK;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// input and output never open together
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output open in the same cycle");

	// sample count bounded by the store
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_SAMPLES))
		else $error("sample count beyond store");

	// products only arrive while a pass runs
	assert property (@(posedge clk) disable iff (!arst_n) v3_q |-> state_q == ST_PASS)
		else $error("product outside a pass");

	// an invalid lag carries zero correlation
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invalid |-> out_data.correlation == '0)
		else $error("invalid result with nonzero correlation");

endmodule

// ===== design/nac_div.sv =====
module nac_div import nac_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CNT_W = $clog2(W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     n_q;
	logic [W-1:0]     r_q;
	logic [W-1:0]     d_q;
	logic [W:0]       r_shift;
	logic             q_bit;

	// one restoring step: shift in the next numerator bit, subtract if it fits
	always_comb begin
		r_shift = {r_q, n_q[W-1]};
		q_bit   = (r_shift >= {1'b0, d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[W-2:0], q_bit};
			r_q <= q_bit ? W'(r_shift - {1'b0, d_q}) : r_shift[W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = n_q;
	assign rem  = r_q;

endmodule

// ===== tb/normalized_autocorrelation_test.sv =====
`timescale 1ns / 1ps

module normalized_autocorrelation_test;
	import nac_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
	localparam int LAG_LIMIT   = DEF_MAX_LAGS;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		bit                         last;
		bit                         flat;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	nac_in_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	nac_out_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic signed [SAMPLE_W-1:0] series_mem [STORE_DEPTH];
	int                         series_len;
	longint                     series_sum;
	logic [NUM_LAGS_W-1:0]      lags_reg;
	logic [LAG_STEP_W-1:0]      step_reg;

	nac_out_t  lag_results [$];
	stim_row_t rows [$];
	int        fail_count;
	int        result_count;
	bit        calm;
	int        cycle_count;

	normalized_autocorrelation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock and cycle limit
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// close the series: compute every lag result and queue it
	task automatic close_series(input bit flat);
		longint                  cnt, num, den, mean, span, t;
		logic signed [127:0]     dev_a, dev_b, var_sum, lag_sum;
		logic [127:0]            mag, scaled, denom, quo;
		int                      nl;
		nac_out_t                res;
		begin
			cnt = series_len;
			mean = 0;
			var_sum = '0;
			if (cnt > 0) begin
				num = 2 * series_sum + cnt;
				den = 2 * cnt;
				mean = (num >= 0) ? num / den : -((-num + den - 1) / den);
				for (int k = 0; k < cnt; k++) begin
					dev_a = series_mem[k] - mean;
					var_sum += dev_a * dev_a;
				end
			end
			nl = lags_reg;
			if (nl == 0) nl = 1;
			if (nl > LAG_LIMIT) nl = LAG_LIMIT;
			for (int n = 0; n < nl; n++) begin
				t = longint'(n) * step_reg;
				res.lag_samples = t[LAG_W-1:0];
				res.correlation = '0;
				res.invalid = 1'b1;
				res.final_result = (n == nl - 1);
				if (!flat && t < cnt && var_sum != 0) begin
					span = cnt - t;
					lag_sum = '0;
					for (longint i = 0; i < span; i++) begin
						dev_a = series_mem[i] - mean;
						dev_b = series_mem[i + t] - mean;
						lag_sum += dev_a * dev_b;
					end
					mag = lag_sum[127] ? -lag_sum : lag_sum;
					scaled = (mag * 128'(cnt)) << 28;
					denom = var_sum * 128'(span);
					quo = (2 * scaled + denom) / (2 * denom);
					if (!lag_sum[127])
						res.correlation = (quo > 128'h7FFF_FFFF) ? CORR_POS_MAX : quo[31:0];
					else
						res.correlation = (quo >= 128'h8000_0000) ? CORR_NEG_MAX : -quo[31:0];
					res.invalid = 1'b0;
				end
				lag_results.push_back(res);
			end
			series_len = 0;
			series_sum = 0;
		end
	endtask

	// one accepted sample
	task automatic take_sample(input logic signed [SAMPLE_W-1:0] s, input bit last,
			input bit flat);
		begin
			if (series_len < STORE_DEPTH) begin
				series_mem[series_len] = s;
				series_len++;
				series_sum += s;
			end
			if (last) close_series(flat);
		end
	endtask

	// offer one sample transaction, with random gaps before it
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input bit last,
			input bit flat);
		begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 99) < 24) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while ($urandom_range(0, 99) < 24) @(negedge clk);
			end
			in_valid <= 1'b1;
			in_data.sample <= s;
			in_data.last <= last;
			do @(posedge clk); while (!in_ready);
			take_sample(s, last, flat);
		end
	endtask

	// drop valid and let the block drain
	task automatic drain;
		begin
			@(negedge clk);
			in_valid <= 1'b0;
			while (lag_results.size() != 0) @(negedge clk);
			repeat (20) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= value[CFG_DATA_W-1:0];
			@(negedge clk);
			cfg_we <= 1'b0;
			if (idx == REG_NUM_LAGS) lags_reg = value[NUM_LAGS_W-1:0];
			else step_reg = value[LAG_STEP_W-1:0];
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int mode,
			input logic signed [SAMPLE_W-1:0] base);
		begin
			case (mode)
				0: pick_sample = $urandom;
				1: pick_sample = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
				2: pick_sample = base;
				default: pick_sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			endcase
		end
	endfunction

	// result checker and receiver with random stalls and one long hold-off
	initial begin
		int hold_left;
		bit held;
		nac_out_t exp_res;
		hold_left = 0;
		held = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				result_count++;
				if (lag_results.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					exp_res = lag_results.pop_front();
					if (out_data.lag_samples !== exp_res.lag_samples) begin
						$error("lag_samples: expected %0d, got %0d",
							exp_res.lag_samples, out_data.lag_samples);
						fail_count++;
					end
					if (out_data.correlation !== exp_res.correlation) begin
						$error("correlation: expected %h, got %h",
							exp_res.correlation, out_data.correlation);
						fail_count++;
					end
					if (out_data.invalid !== exp_res.invalid) begin
						$error("invalid: expected %b, got %b",
							exp_res.invalid, out_data.invalid);
						fail_count++;
					end
					if (out_data.final_result !== exp_res.final_result) begin
						$error("final_result: expected %b, got %b",
							exp_res.final_result, out_data.final_result);
						fail_count++;
					end
				end
			end
			@(negedge clk);
			if (!held && result_count >= 10) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= calm || ($urandom_range(0, 99) >= 24);
		end
	end

	// stimulus
	initial begin
		int lag_cfg [7] = '{64, 1, 0, 127, 17, 8, 30};
		int step_cfg [7] = '{1, 1, 7, 2, 0, 4095, 3};
		int sent, len, mode;
		logic signed [SAMPLE_W-1:0] base;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_NUM_LAGS;
		cfg_data = '0;
		fail_count = 0;
		result_count = 0;
		calm = 0;
		cycle_count = 0;
		series_len = 0;
		series_sum = 0;
		lags_reg = RST_NUM_LAGS;
		step_reg = RST_LAG_STEP;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, flat rows expect all lags invalid with zero value
		rows = '{
			'{32'sh0005_0000, 1, 1},
			'{32'sh7FFF_FFFF, 0, 0}, '{32'sh7FFF_FFFF, 0, 0}, '{32'sh7FFF_FFFF, 1, 1},
			'{32'sh8000_0000, 0, 0}, '{32'sh7FFF_FFFF, 0, 0},
			'{32'sh8000_0000, 0, 0}, '{32'sh7FFF_FFFF, 1, 0},
			'{32'sh0, 0, 0}, '{32'sh0, 0, 0}, '{32'sh0, 0, 0}, '{32'sh0, 1, 1},
			'{32'sh1, 0, 0}, '{-32'sh1, 0, 0}, '{32'sh0001_0000, 0, 0},
			'{-32'sh0001_0000, 0, 0}, '{32'sh4000_0000, 1, 0},
			'{32'sh8000_0000, 0, 0}, '{32'sh0, 0, 0}, '{32'sh0, 0, 0},
			'{32'sh7FFF_FFFF, 1, 0},
			'{32'sh7B, 0, 0}, '{-32'sh1C8, 1, 0}
		};
		foreach (rows[i]) send_sample(rows[i].sample, rows[i].last, rows[i].flat);
		drain();

		// random series under several settings
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(REG_NUM_LAGS, lag_cfg[ph]);
			write_reg(REG_LAG_STEP, step_cfg[ph]);
			calm = (ph == 3);
			sent = 0;
			while (sent < 57) begin
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
				if ($urandom_range(0, 29) == 0) len = $urandom_range(60, 200);
				mode = $urandom_range(0, 9);
				mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
				base = $urandom;
				for (int i = 0; i < len; i++)
					send_sample(pick_sample(mode, base), i == len - 1, 0);
				sent += len;
			end
			calm = 0;
			drain();
		end

		repeat (200) @(negedge clk);
		if (fail_count == 0 && lag_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
